@@ hw/rtl/ordered_event_list_engine_assert.svh @@
// assertion macros shared by the ordered event list engine modules
`ifndef ORDERED_EVENT_LIST_ENGINE_ASSERT_SVH
`define ORDERED_EVENT_LIST_ENGINE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define OEL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OEL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OEL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/oel_pkg.sv @@
// shared types and constants of the ordered event list engine
`default_nettype none

package oel_pkg;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int SEN_W     = 4;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;
  localparam int ENTRY_W   = VAL_W + SEN_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RM_VAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RM_SEN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SIZE   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic append;
    logic clear;
    logic set_full;
    logic set_badpos;
    logic ins_start;
    logic cmp_start;
    logic walk_step;
    logic put_ins;
    logic get_read;
    logic get_done;
    logic cmp_finish;
    logic out_load;
  } oel_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             pos_eq_cnt;
    logic             full;
    logic             empty;
    logic             walk_last;
    logic             out_free;
  } oel_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/oel_if.sv @@
// command and response channel interfaces
`default_nettype none

interface oel_cmd_if;
  import oel_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] event_value;
  logic [SEN_W-1:0]        event_sensor;

  modport source (output valid, output command, output position, output event_value,
                  output event_sensor, input ready);
  modport sink   (input valid, input command, input position, input event_value,
                  input event_sensor, output ready);
endinterface

interface oel_rsp_if;
  import oel_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [SEN_W-1:0]        read_sensor;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic [CNT_OUT_W-1:0]    removed_count;

  modport source (output valid, output status, output read_value, output read_sensor,
                  output entry_count, output removed_count, input ready);
  modport sink   (input valid, input status, input read_value, input read_sensor,
                  input entry_count, input removed_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ordered_event_list_engine.sv @@
// Ordered event list engine: bounded ordered log of events with filtered delete.
// cmd_i carries one command per transaction (append, insert, get, remove by value,
// remove by sensor, size, clear) with a position, a value and a sensor kind.
// rsp_o returns exactly one result per command: status, the entry read by get,
// the entry count after the command and how many entries were removed.
// Entries live in one ram of DEPTH words; insert shifts and removals compact it
// with a pipelined walk that moves one entry per cycle.
// Append, size, clear and rejected commands finish without a walk; get waits for
// the registered ram read; insert walks from the tail down to the position, none
// at the tail, and a removal walks every entry, none on an empty list.
// One command is in work at a time; cmd_i is ready again the cycle after the
// result is loaded into the output register, even while rsp_o still stalls.
// If rsp_o stalls, the finished result waits in the sequencer until the output
// register frees. Reset empties the list; stored words need no clearing since
// only positions below the entry count are ever read.
`default_nettype none

module ordered_event_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oel_cmd_if.sink    cmd_i,
  oel_rsp_if.source  rsp_o
);
  import oel_pkg::*;

  oel_cmd_t  ctl_cmd;
  oel_stat_t dp_stat;

  oel_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(cmd_i.valid),
    .in_ready_o(cmd_i.ready),
    .stat_i    (dp_stat),
    .cmd_o     (ctl_cmd)
  );

  oel_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .stat_o       (dp_stat),
    .in_command_i (cmd_i.command),
    .in_position_i(cmd_i.position),
    .in_value_i   (cmd_i.event_value),
    .in_sensor_i  (cmd_i.event_sensor),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_value_o  (rsp_o.read_value),
    .out_sensor_o (rsp_o.read_sensor),
    .out_entries_o(rsp_o.entry_count),
    .out_removed_o(rsp_o.removed_count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/oel_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module oel_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/oel_ctrl.sv @@
// command sequencer of the ordered event list engine
`default_nettype none
`include "ordered_event_list_engine_assert.svh"

module oel_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire oel_pkg::oel_stat_t stat_i,
  output oel_pkg::oel_cmd_t      cmd_o
);
  import oel_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_GETW   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        unique case (stat_i.command) inside
          CMD_APPEND: begin
            if (stat_i.full) cmd_o.set_full = 1'b1;
            else             cmd_o.append   = 1'b1;
          end
          CMD_INSERT: begin
            if (stat_i.pos_gt_cnt) begin
              cmd_o.set_badpos = 1'b1;
            end else if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
            end else if (stat_i.pos_eq_cnt) begin
              state_d = S_PUT;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = S_WALK;
            end
          end
          CMD_GET: begin
            if (stat_i.pos_ge_cnt) begin
              cmd_o.set_badpos = 1'b1;
            end else begin
              cmd_o.get_read = 1'b1;
              state_d        = S_GETW;
            end
          end
          CMD_RM_VAL, CMD_RM_SEN: begin
            if (!stat_i.empty) begin
              cmd_o.cmp_start = 1'b1;
              state_d         = S_WALK;
            end
          end
          CMD_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) state_d = S_DRAIN;
      end
      // last pending shift or copy is written here
      S_DRAIN: state_d = (stat_i.command == CMD_INSERT) ? S_PUT : S_FIN;
      S_PUT: begin
        cmd_o.put_ins = 1'b1;
        state_d       = S_DONE;
      end
      S_FIN: begin
        cmd_o.cmp_finish = 1'b1;
        state_d          = S_DONE;
      end
      S_GETW: begin
        cmd_o.get_done = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `OEL_ASSERT_IMP(a_load_needs_room, cmd_o.out_load, stat_i.out_free, "result over a pending one")
  `OEL_ASSERT(a_one_writer, !(cmd_o.walk_step && (cmd_o.put_ins || cmd_o.append)), "ram conflict")
  `OEL_ASSERT_NXT(a_capture_decides, cmd_o.capture, !in_ready_o, "new transaction taken while busy")

endmodule

`default_nettype wire

@@ hw/rtl/oel_dp.sv @@
// entry storage, walk pointers and result registers of the event list
`default_nettype none
`include "ordered_event_list_engine_assert.svh"

module oel_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire oel_pkg::oel_cmd_t               cmd_i,
  output oel_pkg::oel_stat_t                   stat_o,
  input  wire logic [oel_pkg::CMD_W-1:0]       in_command_i,
  input  wire logic [oel_pkg::POS_W-1:0]       in_position_i,
  input  wire logic signed [oel_pkg::VAL_W-1:0] in_value_i,
  input  wire logic [oel_pkg::SEN_W-1:0]       in_sensor_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [oel_pkg::STAT_W-1:0]           out_status_o,
  output logic signed [oel_pkg::VAL_W-1:0]     out_value_o,
  output logic [oel_pkg::SEN_W-1:0]            out_sensor_o,
  output logic [oel_pkg::CNT_OUT_W-1:0]        out_entries_o,
  output logic [oel_pkg::CNT_OUT_W-1:0]        out_removed_o
);
  import oel_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [CMD_W-1:0]        cmd_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [SEN_W-1:0]        sen_q;
  logic [CW-1:0]           cnt_q;
  logic [AW-1:0]           rd_q;
  logic [CW-1:0]           wr_q;
  logic                    pend_q;
  logic [AW-1:0]           pend_addr_q;
  logic [STAT_W-1:0]       status_q;
  logic signed [VAL_W-1:0] rv_q;
  logic [SEN_W-1:0]        rs_q;
  logic [CW-1:0]           removed_q;
  logic                    out_valid_q;

  logic [XW-1:0]      pos_x, cnt_x, rd_x, rem_x;
  logic               is_ins, is_rm, hit;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(cnt_q);
  assign rd_x   = XW'(rd_q);
  assign rem_x  = XW'(removed_q);
  assign is_ins = (cmd_q == CMD_INSERT);
  assign is_rm  = (cmd_q == CMD_RM_VAL) || (cmd_q == CMD_RM_SEN);
  assign hit    = (cmd_q == CMD_RM_SEN) ? (rdata[VAL_W +: SEN_W] == sen_q)
                                        : (rdata[VAL_W-1:0] == val_q);

  always_comb begin
    stat_o.command    = cmd_q;
    stat_o.pos_gt_cnt = (pos_x > cnt_x);
    stat_o.pos_ge_cnt = (pos_x >= cnt_x);
    stat_o.pos_eq_cnt = (pos_x == cnt_x);
    stat_o.full       = (cnt_q == CW'(DEPTH));
    stat_o.empty      = (cnt_q == '0);
    stat_o.walk_last  = is_ins ? (rd_x == pos_x) : ((rd_x + XW'(1)) == cnt_x);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // one write port: pending shift/copy, append at tail, or insert at position
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q + AW'(1);
    wdata = rdata;
    if (pend_q) begin
      if (is_ins) begin
        we = 1'b1;
      end else begin
        we    = !hit;
        waddr = wr_q[AW-1:0];
      end
    end else if (cmd_i.append) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = {sen_q, val_q};
    end else if (cmd_i.put_ins) begin
      we    = 1'b1;
      waddr = pos_x[AW-1:0];
      wdata = {sen_q, val_q};
    end
  end

  assign raddr = cmd_i.get_read ? pos_x[AW-1:0] : rd_q;

  oel_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.walk_step;
      if (cmd_i.append || cmd_i.put_ins) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.cmp_finish) begin
        cnt_q <= wr_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= in_command_i;
      pos_q     <= in_position_i;
      val_q     <= in_value_i;
      sen_q     <= in_sensor_i;
      status_q  <= ST_OK;
      rv_q      <= '0;
      rs_q      <= '0;
      removed_q <= '0;
    end
    if (cmd_i.set_full)   status_q <= ST_FULL;
    if (cmd_i.set_badpos) status_q <= ST_BADPOS;
    if (cmd_i.get_done) begin
      rv_q <= rdata[VAL_W-1:0];
      rs_q <= rdata[VAL_W +: SEN_W];
    end
    if (cmd_i.clear)      removed_q <= cnt_q;
    if (cmd_i.cmp_finish) removed_q <= cnt_q - wr_q;

    if (cmd_i.ins_start) begin
      rd_q <= AW'(cnt_q - CW'(1));
    end else if (cmd_i.cmp_start) begin
      rd_q <= '0;
      wr_q <= '0;
    end else if (cmd_i.walk_step) begin
      rd_q <= is_ins ? (rd_q - AW'(1)) : (rd_q + AW'(1));
    end
    pend_addr_q <= rd_q;
    // survivors are packed toward the head
    if (pend_q && !is_ins && !hit) begin
      wr_q <= wr_q + CW'(1);
    end

    if (cmd_i.out_load) begin
      out_status_o  <= status_q;
      out_value_o   <= rv_q;
      out_sensor_o  <= rs_q;
      out_entries_o <= cnt_x[CNT_OUT_W-1:0];
      out_removed_o <= rem_x[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  `OEL_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count beyond depth")
  `OEL_ASSERT_IMP(a_pend_mode, pend_q, is_ins || is_rm, "walk write outside insert or remove")
  `OEL_ASSERT_IMP(a_pack_behind, pend_q && !is_ins, wr_q <= XW'(pend_addr_q), "pack ahead of read")

endmodule

`default_nettype wire
